>>> rtl/sstk_pkg.sv
package sstk_pkg;

  localparam int ITEM_W      = 10;
  localparam int VAL_W       = 16;
  localparam int SCORE_W     = 40;
  localparam int PROD_W      = 32;
  localparam int NUM_ITEMS   = 1024;
  localparam int MAX_ENTRIES = 16384;
  localparam int ENT_AW      = 14;
  localparam int ECNT_W      = 15;
  localparam int MAX_USER    = 256;
  localparam int USR_AW      = 8;
  localparam int UCNT_W      = 9;
  localparam int MAX_TOP_K   = 16;
  localparam int K_W         = 5;
  localparam int BEST_AW     = 4;
  localparam int EPOCH_W     = 8;
  localparam int TOPK_RESET  = 2;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_USER  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ITEM_W-1:0] row_item;
    logic [ITEM_W-1:0] item;
    logic [VAL_W-1:0]  value;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [ITEM_W-1:0]  out_item;
    logic [SCORE_W-1:0] out_score;
    logic               final_res;
    logic               empty_res;
    logic               overflow;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LD_ADV, ST_LD_ENT, ST_START, ST_CLR,
    ST_O_USR, ST_O_USRD, ST_BND_A, ST_BND_B, ST_BND_C,
    ST_O_ENT, ST_O_ENTD, ST_O_SEEN,
    ST_M_RD, ST_M_CMP, ST_M_ACC,
    ST_OF_CMP, ST_OF_INS, ST_EMIT
  } state_t;

endpackage

>>> rtl/sstk_if.sv
interface sstk_in_if;
  logic                valid;
  logic                ready;
  sstk_pkg::in_word_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sstk_out_if;
  logic                valid;
  logic                ready;
  sstk_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/sstk_ram.sv
module sstk_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sparse_similarity_topk_scorer_top.sv
// Sparse item-similarity top-k scorer.
// in_w carries words: load a similarity entry, add a user rated item, or clear
// the similarity store. out_w carries result words. cfg_we/cfg_wdata set top_k,
// which the user must write only while the block is idle; the block itself does
// not enforce this. Both channels handshake on valid and ready. Loads step
// row_start through each skipped row, then write the entry. A user item flagged
// last starts scoring: each candidate costs a row_start lookup, a seen-mark
// check, and a merge-join whose steps each read the user list and entry
// memories, plus an accumulate per matching pair, then a compare and, if the
// score qualifies, a top-k insert. Results leave one per cycle from a single
// output register; a stalled receiver holds it and the scorer waits. in_w stays
// low until the last result is loaded. The candidate marks use an epoch memory;
// every 255 runs, and once after reset, a clearing pass sweeps all 1024 entries,
// during which no word is accepted. Reset clears counters, flags and top_k to 2.
module sparse_similarity_topk_scorer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  sstk_in_if.sink                    in_w,
  sstk_out_if.source                 out_w,
  input  logic                       cfg_we,
  input  logic [sstk_pkg::K_W-1:0]   cfg_wdata
);

  localparam int IW = sstk_pkg::ITEM_W;
  localparam int VW = sstk_pkg::VAL_W;
  localparam int SW = sstk_pkg::SCORE_W;
  localparam int EW = sstk_pkg::ECNT_W;
  localparam int UW = sstk_pkg::UCNT_W;
  localparam int KW = sstk_pkg::K_W;
  localparam int NB = sstk_pkg::MAX_TOP_K;

  sstk_pkg::state_t state_r, state_nxt;

  logic [KW-1:0]  topk_r, topk_nxt;
  logic [EW-1:0]  ecount_r, ecount_nxt;
  logic [IW-1:0]  llr_r, llr_nxt;
  logic [UW-1:0]  ucnt_r, ucnt_nxt;
  logic [IW-1:0]  uprev_r, uprev_nxt;
  logic           ovf_r, ovf_nxt;
  logic [sstk_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic           scoring_r, scoring_nxt;
  logic [IW-1:0]  clr_r, clr_nxt;
  logic [IW-1:0]  prow_r, prow_nxt;
  logic [IW-1:0]  pcol_r, pcol_nxt;
  logic [VW-1:0]  pval_r, pval_nxt;
  logic [UW-1:0]  oi_r, oi_nxt;
  logic [EW-1:0]  oe_r, oe_nxt;
  logic [EW-1:0]  oend_r, oend_nxt;
  logic [IW-1:0]  cand_r, cand_nxt;
  logic [IW-1:0]  bnd_r, bnd_nxt;
  logic           inner_r, inner_nxt;
  logic [EW-1:0]  bstart_r, bstart_nxt;
  logic [EW-1:0]  ie_r, ie_nxt;
  logic [EW-1:0]  iend_r, iend_nxt;
  logic [UW-1:0]  ij_r, ij_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [sstk_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [NB-1:0]  ge_r, ge_nxt;
  logic [IW-1:0]  bitem_r [NB];
  logic [IW-1:0]  bitem_nxt [NB];
  logic [SW-1:0]  bscore_r [NB];
  logic [SW-1:0]  bscore_nxt [NB];
  logic [KW-1:0]  bcnt_r, bcnt_nxt;
  logic [KW-1:0]  on_r, on_nxt;
  sstk_pkg::out_word_t out_r, out_nxt;
  logic           outv_r, outv_nxt;

  logic                       rs_we;
  logic [IW-1:0]              rs_waddr, rs_raddr;
  logic [EW-1:0]              rs_rdata;
  logic                       ent_we;
  logic [IW+VW-1:0]           ent_rdata;
  logic [sstk_pkg::ENT_AW-1:0] ent_raddr;
  logic                       usr_we;
  logic [IW+VW-1:0]           usr_rdata;
  logic [sstk_pkg::USR_AW-1:0] usr_raddr;
  logic                       seen_we;
  logic [IW-1:0]              seen_waddr;
  logic [sstk_pkg::EPOCH_W-1:0] seen_wdata, seen_rdata;

  logic          bret;
  logic [EW-1:0] bb, be;
  logic [SW:0]   acc;
  logic [KW-1:0] kk;
  logic          full;
  logic [IW-1:0] ent_col, usr_item;
  logic [VW-1:0] ent_sim, usr_rate;

  assign ent_col  = ent_rdata[IW+VW-1:VW];
  assign ent_sim  = ent_rdata[VW-1:0];
  assign usr_item = usr_rdata[IW+VW-1:VW];
  assign usr_rate = usr_rdata[VW-1:0];

  assign kk = (topk_r == '0) ? KW'(1) :
              (topk_r > KW'(sstk_pkg::MAX_TOP_K)) ? KW'(sstk_pkg::MAX_TOP_K) : topk_r;
  assign full = (bcnt_r == kk);
  assign acc  = {1'b0, sum_r} + (SW + 1)'(prod_r);

  assign rs_raddr  = (state_r == sstk_pkg::ST_BND_B) ? bnd_r + IW'(1) : bnd_r;
  assign rs_waddr  = llr_r + IW'(1);
  assign ent_raddr = (state_r == sstk_pkg::ST_M_RD) ? ie_r[sstk_pkg::ENT_AW-1:0]
                                                    : oe_r[sstk_pkg::ENT_AW-1:0];
  assign usr_raddr = (state_r == sstk_pkg::ST_M_RD) ? ij_r[sstk_pkg::USR_AW-1:0]
                                                    : oi_r[sstk_pkg::USR_AW-1:0];

  assign in_w.ready = (state_r == sstk_pkg::ST_IDLE);
  assign out_w.valid = outv_r;
  assign out_w.data  = out_r;

  sstk_ram #(.W(EW), .D(sstk_pkg::NUM_ITEMS)) u_row_start (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(ecount_r),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  sstk_ram #(.W(IW + VW), .D(sstk_pkg::MAX_ENTRIES)) u_entry (
    .clk(clk), .we(ent_we), .waddr(ecount_r[sstk_pkg::ENT_AW-1:0]),
    .wdata({pcol_r, pval_r}), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  sstk_ram #(.W(IW + VW), .D(sstk_pkg::MAX_USER)) u_user (
    .clk(clk), .we(usr_we), .waddr(ucnt_r[sstk_pkg::USR_AW-1:0]),
    .wdata({in_w.data.item, in_w.data.value}), .raddr(usr_raddr), .rdata(usr_rdata)
  );

  sstk_ram #(.W(sstk_pkg::EPOCH_W), .D(sstk_pkg::NUM_ITEMS)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
    .raddr(ent_col), .rdata(seen_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    topk_nxt    = cfg_we ? cfg_wdata : topk_r;
    ecount_nxt  = ecount_r;
    llr_nxt     = llr_r;
    ucnt_nxt    = ucnt_r;
    uprev_nxt   = uprev_r;
    ovf_nxt     = ovf_r;
    epoch_nxt   = epoch_r;
    scoring_nxt = scoring_r;
    clr_nxt     = clr_r;
    prow_nxt    = prow_r;
    pcol_nxt    = pcol_r;
    pval_nxt    = pval_r;
    oi_nxt      = oi_r;
    oe_nxt      = oe_r;
    oend_nxt    = oend_r;
    cand_nxt    = cand_r;
    bnd_nxt     = bnd_r;
    inner_nxt   = inner_r;
    bstart_nxt  = bstart_r;
    ie_nxt      = ie_r;
    iend_nxt    = iend_r;
    ij_nxt      = ij_r;
    sum_nxt     = sum_r;
    prod_nxt    = prod_r;
    ge_nxt      = ge_r;
    bitem_nxt   = bitem_r;
    bscore_nxt  = bscore_r;
    bcnt_nxt    = bcnt_r;
    on_nxt      = on_r;
    out_nxt     = out_r;
    outv_nxt    = (outv_r && out_w.ready) ? 1'b0 : outv_r;
    rs_we       = 1'b0;
    ent_we      = 1'b0;
    usr_we      = 1'b0;
    seen_we     = 1'b0;
    seen_waddr  = cand_r;
    seen_wdata  = epoch_r;
    bret        = 1'b0;
    bb          = ecount_r;
    be          = ecount_r;

    case (state_r)
      sstk_pkg::ST_IDLE: begin
        if (in_w.valid) begin
          case (in_w.data.command)
            sstk_pkg::CMD_LOAD: begin
              prow_nxt = in_w.data.row_item;
              pcol_nxt = in_w.data.item;
              pval_nxt = in_w.data.value;
              if (in_w.data.row_item > llr_r) begin
                state_nxt = sstk_pkg::ST_LD_ADV;
              end else if (in_w.data.row_item == llr_r) begin
                state_nxt = sstk_pkg::ST_LD_ENT;
              end
            end
            sstk_pkg::CMD_CLEAR: begin
              ecount_nxt = '0;
              llr_nxt    = '0;
            end
            sstk_pkg::CMD_USER: begin
              if (ucnt_r == '0 || in_w.data.item > uprev_r) begin
                if (ucnt_r == UW'(sstk_pkg::MAX_USER)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  usr_we    = 1'b1;
                  ucnt_nxt  = ucnt_r + UW'(1);
                  uprev_nxt = in_w.data.item;
                end
              end
              if (in_w.data.last) begin
                state_nxt = sstk_pkg::ST_START;
              end
            end
            default: begin
            end
          endcase
        end
      end
      sstk_pkg::ST_LD_ADV: begin
        rs_we   = 1'b1;
        llr_nxt = llr_r + IW'(1);
        if (llr_r + IW'(1) == prow_r) begin
          state_nxt = sstk_pkg::ST_LD_ENT;
        end
      end
      sstk_pkg::ST_LD_ENT: begin
        if (ecount_r == EW'(sstk_pkg::MAX_ENTRIES)) begin
          ovf_nxt = 1'b1;
        end else begin
          ent_we     = 1'b1;
          ecount_nxt = ecount_r + EW'(1);
        end
        state_nxt = sstk_pkg::ST_IDLE;
      end
      sstk_pkg::ST_START: begin
        bcnt_nxt    = '0;
        oi_nxt      = '0;
        scoring_nxt = 1'b1;
        if (epoch_r == '1) begin
          clr_nxt   = '0;
          state_nxt = sstk_pkg::ST_CLR;
        end else begin
          epoch_nxt = epoch_r + 1'b1;
          state_nxt = sstk_pkg::ST_O_USR;
        end
      end
      sstk_pkg::ST_CLR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_r;
        seen_wdata = '0;
        clr_nxt    = clr_r + IW'(1);
        if (clr_r == '1) begin
          epoch_nxt = sstk_pkg::EPOCH_W'(1);
          state_nxt = scoring_r ? sstk_pkg::ST_O_USR : sstk_pkg::ST_IDLE;
        end
      end
      sstk_pkg::ST_O_USR: begin
        if (oi_r == ucnt_r) begin
          on_nxt    = '0;
          state_nxt = sstk_pkg::ST_EMIT;
        end else begin
          state_nxt = sstk_pkg::ST_O_USRD;
        end
      end
      sstk_pkg::ST_O_USRD: begin
        bnd_nxt   = usr_item;
        inner_nxt = 1'b0;
        state_nxt = sstk_pkg::ST_BND_A;
      end
      sstk_pkg::ST_BND_A: begin
        if (bnd_r > llr_r) begin
          bret = 1'b1;
        end else begin
          state_nxt = sstk_pkg::ST_BND_B;
        end
      end
      sstk_pkg::ST_BND_B: begin
        bstart_nxt = (bnd_r == '0) ? '0 : rs_rdata;
        state_nxt  = sstk_pkg::ST_BND_C;
      end
      sstk_pkg::ST_BND_C: begin
        bret = 1'b1;
        bb   = bstart_r;
        be   = (bnd_r == llr_r) ? ecount_r : rs_rdata;
      end
      sstk_pkg::ST_O_ENT: begin
        if (oe_r == oend_r) begin
          oi_nxt    = oi_r + UW'(1);
          state_nxt = sstk_pkg::ST_O_USR;
        end else begin
          state_nxt = sstk_pkg::ST_O_ENTD;
        end
      end
      sstk_pkg::ST_O_ENTD: begin
        cand_nxt  = ent_col;
        state_nxt = sstk_pkg::ST_O_SEEN;
      end
      sstk_pkg::ST_O_SEEN: begin
        oe_nxt = oe_r + EW'(1);
        if (seen_rdata == epoch_r) begin
          state_nxt = sstk_pkg::ST_O_ENT;
        end else begin
          seen_we   = 1'b1;
          bnd_nxt   = cand_r;
          inner_nxt = 1'b1;
          state_nxt = sstk_pkg::ST_BND_A;
        end
      end
      sstk_pkg::ST_M_RD: begin
        if (ij_r == ucnt_r || ie_r == iend_r) begin
          state_nxt = sstk_pkg::ST_OF_CMP;
        end else begin
          state_nxt = sstk_pkg::ST_M_CMP;
        end
      end
      sstk_pkg::ST_M_CMP: begin
        state_nxt = sstk_pkg::ST_M_RD;
        if (usr_item < ent_col) begin
          ij_nxt = ij_r + UW'(1);
        end else if (usr_item > ent_col) begin
          ie_nxt = ie_r + EW'(1);
        end else begin
          prod_nxt  = sstk_pkg::PROD_W'(usr_rate) * sstk_pkg::PROD_W'(ent_sim);
          ij_nxt    = ij_r + UW'(1);
          ie_nxt    = ie_r + EW'(1);
          state_nxt = sstk_pkg::ST_M_ACC;
        end
      end
      sstk_pkg::ST_M_ACC: begin
        sum_nxt   = acc[SW] ? '1 : acc[SW-1:0];
        state_nxt = sstk_pkg::ST_M_RD;
      end
      sstk_pkg::ST_OF_CMP: begin
        if (full && sum_r <= bscore_r[sstk_pkg::BEST_AW'(kk - KW'(1))]) begin
          state_nxt = sstk_pkg::ST_O_ENT;
        end else begin
          for (int m = 0; m < NB; m++) begin
            ge_nxt[m] = (KW'(m) < bcnt_r) && (bscore_r[m] >= sum_r);
          end
          state_nxt = sstk_pkg::ST_OF_INS;
        end
      end
      sstk_pkg::ST_OF_INS: begin
        for (int m = 0; m < NB; m++) begin
          if (!ge_r[m]) begin
            if (m == 0 || ge_r[(m == 0) ? 0 : m - 1]) begin
              bitem_nxt[m]  = cand_r;
              bscore_nxt[m] = sum_r;
            end else begin
              bitem_nxt[m]  = bitem_r[(m == 0) ? 0 : m - 1];
              bscore_nxt[m] = bscore_r[(m == 0) ? 0 : m - 1];
            end
          end
        end
        if (!full) begin
          bcnt_nxt = bcnt_r + KW'(1);
        end
        state_nxt = sstk_pkg::ST_O_ENT;
      end
      sstk_pkg::ST_EMIT: begin
        if (!outv_r || out_w.ready) begin
          outv_nxt          = 1'b1;
          out_nxt.overflow  = ovf_r;
          if (bcnt_r == '0) begin
            out_nxt.out_item  = '0;
            out_nxt.out_score = '0;
            out_nxt.final_res = 1'b1;
            out_nxt.empty_res = 1'b1;
            ucnt_nxt          = '0;
            state_nxt         = sstk_pkg::ST_IDLE;
          end else begin
            out_nxt.out_item  = bitem_r[on_r[sstk_pkg::BEST_AW-1:0]];
            out_nxt.out_score = bscore_r[on_r[sstk_pkg::BEST_AW-1:0]];
            out_nxt.final_res = (on_r + KW'(1) == bcnt_r);
            out_nxt.empty_res = 1'b0;
            on_nxt            = on_r + KW'(1);
            if (on_r + KW'(1) == bcnt_r) begin
              ucnt_nxt  = '0;
              state_nxt = sstk_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = sstk_pkg::ST_IDLE;
      end
    endcase

    if (bret) begin
      if (inner_r) begin
        ie_nxt    = bb;
        iend_nxt  = be;
        ij_nxt    = '0;
        sum_nxt   = '0;
        state_nxt = sstk_pkg::ST_M_RD;
      end else begin
        oe_nxt    = bb;
        oend_nxt  = be;
        state_nxt = sstk_pkg::ST_O_ENT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sstk_pkg::ST_CLR;
      topk_r    <= KW'(sstk_pkg::TOPK_RESET);
      ecount_r  <= '0;
      llr_r     <= '0;
      ucnt_r    <= '0;
      ovf_r     <= 1'b0;
      epoch_r   <= '0;
      scoring_r <= 1'b0;
      clr_r     <= '0;
      bcnt_r    <= '0;
      outv_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      topk_r    <= topk_nxt;
      ecount_r  <= ecount_nxt;
      llr_r     <= llr_nxt;
      ucnt_r    <= ucnt_nxt;
      ovf_r     <= ovf_nxt;
      epoch_r   <= epoch_nxt;
      scoring_r <= scoring_nxt;
      clr_r     <= clr_nxt;
      bcnt_r    <= bcnt_nxt;
      outv_r    <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    uprev_r  <= uprev_nxt;
    prow_r   <= prow_nxt;
    pcol_r   <= pcol_nxt;
    pval_r   <= pval_nxt;
    oi_r     <= oi_nxt;
    oe_r     <= oe_nxt;
    oend_r   <= oend_nxt;
    cand_r   <= cand_nxt;
    bnd_r    <= bnd_nxt;
    inner_r  <= inner_nxt;
    bstart_r <= bstart_nxt;
    ie_r     <= ie_nxt;
    iend_r   <= iend_nxt;
    ij_r     <= ij_nxt;
    sum_r    <= sum_nxt;
    prod_r   <= prod_nxt;
    ge_r     <= ge_nxt;
    bitem_r  <= bitem_nxt;
    bscore_r <= bscore_nxt;
    on_r     <= on_nxt;
    out_r    <= out_nxt;
  end

endmodule
